@@ src/qpd_pkg.sv @@
`timescale 1ns / 1ps
// Quoted-printable decoder package: queue entry type, byte constants, hex decode.
// No dependencies.
package qpd_pkg;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic       v0;
		logic [7:0] b1;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic valid;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.valid = 1'b1;
			r.nib   = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.valid = 1'b1;
			r.nib   = 4'(c - 8'h37);
		end
		return r;
	endfunction

endpackage

@@ src/qpd_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts encoded bytes, tracks escape state, builds queue entries.
// Depends on qpd_pkg.
module qpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  qpd_pkg::fifo_stat_t fifo_stat,
	output logic              push,
	output qpd_pkg::entry_t   push_entry
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_EQ,
		PH_HELD
	} phase_t;

	phase_t       phase_q, nphase;
	logic [7:0]   held_q, nheld;
	logic [1:0]   cnt;
	logic [7:0]   e0, e1;
	qpd_pkg::hex_t hv_h, hv_b;
	logic         accept;

	assign hv_h = qpd_pkg::hex_decode(held_q);
	assign hv_b = qpd_pkg::hex_decode(s_tdata);

	always_comb begin
		cnt    = 2'd0;
		e0     = '0;
		e1     = '0;
		nphase = phase_q;
		nheld  = held_q;
		unique case (phase_q)
			PH_EQ: begin
				nheld  = s_tdata;
				nphase = PH_HELD;
			end
			PH_HELD: begin
				nheld  = '0;
				nphase = PH_IDLE;
				priority if (hv_h.valid && hv_b.valid) begin
					cnt = 2'd1;
					e0  = {hv_h.nib, hv_b.nib};
				end else if (held_q == qpd_pkg::CH_CR && s_tdata == qpd_pkg::CH_LF) begin
					cnt = 2'd0;
				end else if (held_q == qpd_pkg::CH_EQ) begin
					nphase = PH_HELD;
					nheld  = s_tdata;
				end else begin
					cnt = 2'd1;
					e0  = held_q;
					if (s_tdata == qpd_pkg::CH_EQ) begin
						nphase = PH_EQ;
					end else begin
						cnt = 2'd2;
						e1  = s_tdata;
					end
				end
			end
			default: begin
				nphase = PH_IDLE;
				if (s_tdata == qpd_pkg::CH_EQ) begin
					nphase = PH_EQ;
				end else begin
					cnt = 2'd1;
					e0  = s_tdata;
				end
			end
		endcase
	end

	assign s_tready = !fifo_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && ((cnt != 2'd0) || s_tlast);

	assign push_entry.two  = (cnt == 2'd2);
	assign push_entry.b0   = e0;
	assign push_entry.v0   = (cnt != 2'd0);
	assign push_entry.b1   = e1;
	assign push_entry.last = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				phase_q <= PH_IDLE;
				held_q  <= '0;
			end else begin
				phase_q <= nphase;
				held_q  <= nheld;
			end
		end
	end

endmodule

@@ src/qpd_fifo.sv @@
`timescale 1ns / 1ps
// Short entry queue between front and back ends.
// Depends on qpd_pkg.
module qpd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qpd_pkg::entry_t     push_entry,
	input  logic                pop,
	output qpd_pkg::entry_t     head,
	output qpd_pkg::fifo_stat_t stat
);

	qpd_pkg::entry_t                 mem_q [qpd_pkg::DEPTH];
	logic [qpd_pkg::PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [qpd_pkg::CNT_W-1:0]       count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == qpd_pkg::CNT_W'(qpd_pkg::DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/qpd_back.sv @@
`timescale 1ns / 1ps
// Back end: splits queue entries into single results behind an output register.
// Depends on qpd_pkg.
module qpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  qpd_pkg::entry_t     head,
	input  qpd_pkg::fifo_stat_t fifo_stat,
	output logic                pop,
	output logic                half,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);

	logic       load;
	logic       half_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       user_q;
	logic       last_q;

	assign load = !valid_q || m_tready;
	assign pop  = load && !fifo_stat.empty && (half_q || !head.two);
	assign half = half_q;

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= !fifo_stat.empty;
			if (!fifo_stat.empty) begin
				half_q <= !half_q && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !fifo_stat.empty) begin
			if (half_q) begin
				byte_q <= head.b1;
				user_q <= 1'b1;
				last_q <= head.last;
			end else begin
				byte_q <= head.b0;
				user_q <= head.v0;
				last_q <= head.last && !head.two;
			end
		end
	end

endmodule

@@ src/quoted_printable_decoder_top.sv @@
`timescale 1ns / 1ps
// Quoted-printable decoder top level: front end, entry queue, back end.
// Depends on qpd_pkg, qpd_front, qpd_fifo, qpd_back.
//
// Channel  Dir  Signals                     Payload
// s_*      in   tvalid tready tdata tlast   tdata[7:0] data_byte, tlast is_last
// m_*      out  tvalid tready tdata tuser   tdata[7:0] out_byte, tuser byte_valid,
//                tlast                       tlast end_of_message
//
// One encoded byte per cycle while the queue is not full; a result is written into the
// entry queue when its byte is accepted and then loaded into the output register.
// An escape giving two bytes keeps its queue entry until both are sent; the 4-entry queue
// absorbs this, so input stalls only when the queue fills.
// Reset clears escape state, queue pointers and output valid; no clearing pass.
module quoted_printable_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] byte_valid
	output logic       m_tlast
);

	logic                push, pop, half;
	qpd_pkg::entry_t     push_entry, head;
	qpd_pkg::fifo_stat_t fifo_stat;

	qpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	qpd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (fifo_stat)
	);

	qpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.half      (half),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fifo_stat.full))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("pop from empty queue");

	a_half_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		half |-> !fifo_stat.empty)
		else $error("second byte pending with empty queue");

	a_half_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(half && m_tvalid) |-> !m_tlast)
		else $error("end of message before second byte");
`endif

endmodule
